/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another one on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// Types and constants of the bidirectional peak spread block.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int MAX_BARS  = 64;
	localparam int LEVEL_W   = 16;
	localparam int BAR_IDX_W = $clog2(MAX_BARS);
	localparam int FACTOR_W  = 17;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = LEVEL_W + FACTOR_W;

	localparam logic [FACTOR_W-1:0]  FACTOR_ONE   = FACTOR_W'(65536);
	localparam logic [FACTOR_W-1:0]  FACTOR_RESET = FACTOR_W'(43691);
	localparam logic [BAR_IDX_W-1:0] LAST_IDX     = BAR_IDX_W'(MAX_BARS - 1);

	typedef struct packed {
		logic [LEVEL_W-1:0] bar_level;
		logic               frame_end;
	} bps_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] spread_level;
		logic               frame_last;
	} bps_result_t;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_FWD  = 4'b0010,
		ST_BWD  = 4'b0100,
		ST_OUT  = 4'b1000
	} bps_state_t;

endpackage

/* rtl/bidirectional_peak_spread.sv */
// ----------------------------------------------------------------------------
// bidirectional_peak_spread
// Two-sided decaying maximum over one frame of spectrum bar levels.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  request   start / busy       item   (bar_level, frame_end)
//  result    strobe             result (spread_level, frame_last)
//  config    cfg_we             cfg_wdata (falloff_factor, Q1.16)
//
//  Loading takes one bar per cycle; busy stays low until the frame ends.
//  Busy then stays high through the forward pass, backward pass and readout,
//  which step each bar in a wait phase and an update phase, set by the shared
//  multiplier with its product register and the registered RAM read.
//  Results come out on strobe, one per bar; the receiver cannot stall.
//  Reset clears the sequencer, the bar count and the carry; the stores
//  hold no reset value and are only read where written in the same frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bidirectional_peak_spread (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  bps_pkg::bps_item_t            item,
	output logic                          busy,
	output logic                          strobe,
	output bps_pkg::bps_result_t          result,
	input  logic                          cfg_we,
	input  logic [bps_pkg::FACTOR_W-1:0]  cfg_wdata
);

	import bps_pkg::*;

	bps_state_t            state_q;
	logic                  phase_q;
	logic [BAR_IDX_W-1:0]  idx_q;
	logic [BAR_IDX_W-1:0]  last_q;
	logic [BAR_IDX_W-1:0]  load_cnt_q;
	logic [LEVEL_W-1:0]    carry_q;
	logic [FACTOR_W-1:0]   factor_q;
	logic [PROD_W-1:0]     prod_q;

	logic                  accept;
	logic [LEVEL_W-1:0]    prod_lvl;
	logic [LEVEL_W-1:0]    carry_nxt;
	logic [LEVEL_W-1:0]    bwd_lvl;
	logic                  samp_we;
	logic [LEVEL_W-1:0]    samp_rd;
	logic                  sprd_we;
	logic [LEVEL_W-1:0]    sprd_wdata;
	logic [LEVEL_W-1:0]    sprd_rd;

	assign busy   = (state_q != ST_LOAD);
	assign accept = start && !busy;

	// Decay the carry and take the larger of it and the bar level; the backward pass also takes the forward spread
	assign prod_lvl  = prod_q[FRAC_W +: LEVEL_W];
	assign carry_nxt = (samp_rd > prod_lvl) ? samp_rd : prod_lvl;
	assign bwd_lvl   = (carry_nxt > sprd_rd) ? carry_nxt : sprd_rd;

	// Drive the stores
	assign samp_we    = accept;
	assign sprd_we    = phase_q && ((state_q == ST_FWD) || (state_q == ST_BWD));
	assign sprd_wdata = (state_q == ST_FWD) ? carry_nxt : bwd_lvl;

	bps_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (MAX_BARS)
	) u_sample_ram (
		.clk   (clk),
		.we    (samp_we),
		.waddr (load_cnt_q),
		.wdata (item.bar_level),
		.raddr (idx_q),
		.rdata (samp_rd)
	);

	bps_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (MAX_BARS)
	) u_spread_ram (
		.clk   (clk),
		.we    (sprd_we),
		.waddr (idx_q),
		.wdata (sprd_wdata),
		.raddr (idx_q),
		.rdata (sprd_rd)
	);

	// Shared multiplier: carry times saturated factor, registered
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(carry_q) * PROD_W'(factor_q);
	end

	// Hold the falloff factor, limited to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (cfg_we) begin
			factor_q <= (cfg_wdata > FACTOR_ONE) ? FACTOR_ONE : cfg_wdata;
		end
	end

	// Sequence load, forward pass, backward pass and readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			phase_q    <= 1'b0;
			idx_q      <= '0;
			last_q     <= '0;
			load_cnt_q <= '0;
			carry_q    <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (item.frame_end || (load_cnt_q == LAST_IDX)) begin
							last_q     <= load_cnt_q;
							load_cnt_q <= '0;
							idx_q      <= '0;
							phase_q    <= 1'b0;
							carry_q    <= '0;
							state_q    <= ST_FWD;
						end else begin
							load_cnt_q <= load_cnt_q + 1'b1;
						end
					end
				end
				ST_FWD: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (idx_q == last_q) begin
							carry_q <= '0;
							state_q <= ST_BWD;
						end else begin
							carry_q <= carry_nxt;
							idx_q   <= idx_q + 1'b1;
						end
					end
				end
				ST_BWD: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						carry_q <= carry_nxt;
						if (idx_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				ST_OUT: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (idx_q == last_q) begin
							idx_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Present each bar straight from the spread store read register
	assign strobe              = (state_q == ST_OUT) && phase_q;
	assign result.spread_level = sprd_rd;
	assign result.frame_last   = (idx_q == last_q);

	`ASSERT_IMPLIES(a_strobe_busy, clk, arst_n, strobe, busy, "result outside a busy frame")
	`ASSERT_NEXT(a_last_frees, clk, arst_n, strobe && result.frame_last, !busy, "no release after last")
	`ASSERT_IMPLIES(a_load_idle, clk, arst_n, samp_we, state_q == ST_LOAD, "sample write while busy")
	`ASSERT_IMPLIES(a_factor_sat, clk, arst_n, 1'b1, factor_q <= FACTOR_ONE, "factor above one")

endmodule

/* rtl/bps_ram.sv */
// ----------------------------------------------------------------------------
// bps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bidirectional_peak_spread testbench
// Feeds frames of bar levels through the start/busy port and checks every
// strobed result against an in-bench model of the two-sided decaying max.
// The falloff factor is changed between frames while the block is idle,
// covering zero, unity, the reset value and values above unity.
// ----------------------------------------------------------------------------
module testbench;

	import bps_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 16;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	bps_item_t         item      = '0;
	logic              busy;
	logic              strobe;
	bps_result_t       result;
	logic              cfg_we    = 1'b0;
	logic [FACTOR_W-1:0] cfg_wdata = '0;

	// Pending requests, expected results and the model state
	bps_item_t         bar_requests[$];
	bps_result_t       spread_due[$];
	logic [FACTOR_W-1:0] falloff_q = FACTOR_RESET;
	logic [LEVEL_W-1:0]  frame_levels[MAX_BARS];
	int                frame_bars   = 0;
	logic              took_request = 1'b0;
	int                gap_left     = 0;
	int                burst_left   = 0;
	int                idle_cycles  = 0;
	int                fail_count   = 0;

	bidirectional_peak_spread i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.strobe    (strobe),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Carry a peak one bar further: decay it, then keep the larger one
	function automatic logic [LEVEL_W-1:0] decay_peak(logic [LEVEL_W-1:0] lvl,
			logic [LEVEL_W-1:0] carry);
		logic [FACTOR_W-1:0] f;
		logic [PROD_W-1:0]   prod;
		logic [LEVEL_W-1:0]  decayed;
		f       = (falloff_q > FACTOR_ONE) ? FACTOR_ONE : falloff_q;
		prod    = PROD_W'(carry) * PROD_W'(f);
		decayed = prod[FRAC_W +: LEVEL_W];
		return (lvl > decayed) ? lvl : decayed;
	endfunction

	// Store one bar; at frame end run both passes and queue the frame
	function automatic void load_bar_and_spread(bps_item_t req);
		logic [LEVEL_W-1:0] spread[MAX_BARS];
		logic [LEVEL_W-1:0] carry;
		bps_result_t        r;
		int                 n;
		frame_levels[frame_bars] = req.bar_level;
		frame_bars++;
		if (req.frame_end || frame_bars == MAX_BARS) begin
			n     = frame_bars;
			carry = '0;
			for (int i = 0; i < n; i++) begin
				carry     = decay_peak(frame_levels[i], carry);
				spread[i] = carry;
			end
			carry = '0;
			for (int i = n - 1; i >= 0; i--) begin
				carry = decay_peak(frame_levels[i], carry);
				if (carry > spread[i])
					spread[i] = carry;
			end
			for (int i = 0; i < n; i++) begin
				r.spread_level = spread[i];
				r.frame_last   = (i == n - 1);
				spread_due.push_back(r);
			end
			frame_bars = 0;
		end
	endfunction

	// Mostly short gaps, a few long ones, and gap-free bursts
	function automatic int next_gap();
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			burst_left = $urandom_range(8, 30);
			return 0;
		end
		if (pick < 50)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [LEVEL_W-1:0] random_level();
		case ($urandom_range(0, 3))
			0: begin
				return LEVEL_W'($urandom);
			end
			1: begin
				return '0;
			end
			2: begin
				return LEVEL_W'($urandom_range(0, 255));
			end
			default: begin
				return 16'hFFFF - LEVEL_W'($urandom_range(0, 4095));
			end
		endcase
	endfunction

	function automatic void add_bar(logic [LEVEL_W-1:0] lvl, logic fend);
		bps_item_t req;
		req.bar_level = lvl;
		req.frame_end = fend;
		bar_requests.push_back(req);
	endfunction

	// Frames shorter than the store end on frame_end; full ones end anyway
	function automatic int add_random_frame(int bars, logic end_on_last);
		for (int i = 0; i < bars; i++)
			add_bar(random_level(), (i == bars - 1) ? end_on_last : 1'b0);
		return bars;
	endfunction

	// Hold until every request is taken and every result is back
	task automatic drain_and_settle();
		while (bar_requests.size() != 0 || start || spread_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_falloff(logic [FACTOR_W-1:0] value);
		cfg_wdata = value;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Request driver: present the next bar once the current one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || took_request) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (bar_requests.size() != 0) begin
					item     <= bar_requests.pop_front();
					start    <= 1'b1;
					gap_left = next_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: update the model, check results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			took_request <= start && !busy;
			if (cfg_we)
				falloff_q = cfg_wdata;
			if (start && !busy)
				load_bar_and_spread(item);
			if (strobe) begin
				if (spread_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h/%b", $time,
						result.spread_level, result.frame_last);
					fail_count++;
				end else begin
					if (result.spread_level !== spread_due[0].spread_level) begin
						$display("%0t: spread_level expected %h, got %h", $time,
							spread_due[0].spread_level, result.spread_level);
						fail_count++;
					end
					if (result.frame_last !== spread_due[0].frame_last) begin
						$display("%0t: frame_last expected %b, got %b", $time,
							spread_due[0].frame_last, result.frame_last);
						fail_count++;
					end
					void'(spread_due.pop_front());
				end
			end
			if ((start && !busy) || strobe || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, %0d results outstanding", $time, spread_due.size());
				$display("bidirectional_peak_spread regression: fail");
				$finish;
			end
		end
	end

	// Stimulus phases, each separated by a full drain
	initial begin
		logic [FACTOR_W-1:0] factors[6];
		int                  queued;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames at the reset factor: extremes, lone bars, spread
		add_bar(16'hFFFF, 1'b1);
		add_bar(16'h0000, 1'b1);
		add_bar(16'h0000, 1'b0);
		add_bar(16'h0001, 1'b0);
		add_bar(16'hFFFF, 1'b0);
		add_bar(16'h0000, 1'b0);
		add_bar(16'h0000, 1'b0);
		add_bar(16'h8000, 1'b0);
		add_bar(16'h0000, 1'b1);
		add_bar(16'h4000, 1'b0);
		add_bar(16'h7FFF, 1'b0);
		add_bar(16'h1234, 1'b1);
		drain_and_settle();

		// Zero factor: no spread at all
		write_falloff('0);
		add_bar(16'h0000, 1'b0);
		add_bar(16'hFFFF, 1'b0);
		add_bar(16'h0000, 1'b1);
		drain_and_settle();

		// Unity factor: the peak carries undecayed
		write_falloff(FACTOR_ONE);
		add_bar(16'h0000, 1'b0);
		add_bar(16'hABCD, 1'b0);
		add_bar(16'h0000, 1'b0);
		add_bar(16'h0002, 1'b1);
		drain_and_settle();

		// Factor above unity saturates, including the largest value
		write_falloff(FACTOR_ONE + 1);
		add_bar(16'h0000, 1'b0);
		add_bar(16'hFFFF, 1'b0);
		add_bar(16'h0000, 1'b1);
		drain_and_settle();
		write_falloff(17'h1FFFF);
		add_bar(16'h8001, 1'b0);
		add_bar(16'h0000, 1'b1);
		drain_and_settle();

		// Random frames under a range of factors; one phase fills the store
		factors[0] = 17'($urandom_range(0, 65536));
		factors[1] = 17'd1;
		factors[2] = 17'($urandom_range(60000, 65535));
		factors[3] = FACTOR_RESET;
		factors[4] = 17'($urandom);
		factors[5] = 17'($urandom_range(0, 65536));
		for (int p = 0; p < 6; p++) begin
			write_falloff(factors[p]);
			queued = 0;
			if (p == 2)
				queued += add_random_frame(MAX_BARS, 1'($urandom_range(0, 1)));
			while (queued < 2)
				queued += add_random_frame(($urandom_range(0, 9) < 7) ?
					$urandom_range(1, 6) : $urandom_range(7, 16), 1'b1);
			drain_and_settle();
		end

		if (fail_count == 0) begin
			$display("bidirectional_peak_spread regression: pass");
		end else begin
			$display("bidirectional_peak_spread regression: fail");
		end
		$finish;
	end

endmodule
